/* rtl/fcd_pkg.sv */
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants for the FLI chunk decoder
// Request structs for both channels, chunk codes and result kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcd_pkg;

  // Default geometry
  localparam int unsigned FRAME_BYTES_DEF = 64000;
  localparam int unsigned RUN_LINES_DEF   = 200;
  localparam logic [15:0] LINE_WIDTH_RST  = 16'd320;

  // Operation codes of an input request
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Chunk type codes
  localparam logic [15:0] CT_COLOR = 16'd11;
  localparam logic [15:0] CT_DELTA = 16'd12;
  localparam logic [15:0] CT_BLACK = 16'd13;
  localparam logic [15:0] CT_BRUN  = 16'd15;
  localparam logic [15:0] CT_COPY  = 16'd16;

  // Result kinds
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_PAL  = 2'd2;

  typedef enum logic [2:0] {
    CH_NONE  = 3'd0,
    CH_COLOR = 3'd1,
    CH_DELTA = 3'd2,
    CH_COPY  = 3'd3,
    CH_BRUN  = 3'd4
  } chunk_t;

  typedef enum logic [3:0] {
    PH_W0_LO = 4'd0,
    PH_W0_HI = 4'd1,
    PH_W1_LO = 4'd2,
    PH_W1_HI = 4'd3,
    PH_PKTS  = 4'd4,
    PH_SKIP  = 4'd5,
    PH_SIZE  = 4'd6,
    PH_LIT   = 4'd7,
    PH_FILL  = 4'd8,
    PH_PSKIP = 4'd9,
    PH_PNUM  = 4'd10,
    PH_COMP  = 4'd11
  } phase_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] chunk_type;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] run_count;
    logic [7:0]  value;
  } out_item_t;

  // Engine to output register
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } res_req_t;

endpackage

/* rtl/fcd_in_reg.sv */
// ----------------------------------------------------------------------------
// fcd_in_reg: input request register
// Captures one request and holds it until the engine takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_in_reg import fcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     take,
  output logic     valid_r,
  output in_item_t item_r
);

  logic valid_nxt;
  logic accept;

  // Stall only while a held request is not taken this cycle
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/fcd_engine.sv */
// ----------------------------------------------------------------------------
// fcd_engine: chunk decoding state machine
// Updates the decoder state for one request per cycle while advance is high, and forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_engine import fcd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int unsigned RUN_LINES   = RUN_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  in_item_t    item,
  input  logic [15:0] line_width,
  output res_req_t    res
);

  typedef struct packed {
    chunk_t      active;
    phase_t      phase;
    logic [7:0]  hold;
    logic [15:0] line_addr;
    logic [15:0] cursor;
    logic [15:0] lines_left;
    logic [15:0] pkts_left;
    logic [8:0]  run_left;
    logic [7:0]  pal_idx;
    logic [1:0]  comp_idx;
    logic [15:0] copy_left;
  } state_t;

  localparam logic [15:0] FRAME_CNT = 16'(FRAME_BYTES);
  localparam logic [15:0] RUN_CNT   = 16'(RUN_LINES);

  state_t st_r;
  state_t st_nxt;

  // Finish a line: step to the next line or close the chunk
  function automatic state_t end_line(state_t s, logic [15:0] lw);
    state_t o;
    o           = s;
    o.line_addr = s.line_addr + lw;
    o.lines_left = s.lines_left - 16'd1;
    if (o.lines_left == 16'd0) begin
      o.active = CH_NONE;
    end else begin
      o.cursor = o.line_addr;
      o.phase  = PH_PKTS;
    end
    return o;
  endfunction

  // Finish a packet: next packet of the line, or end the line
  function automatic state_t end_packet(state_t s, logic [15:0] lw);
    state_t o;
    o           = s;
    o.pkts_left = s.pkts_left - 16'd1;
    if (o.pkts_left == 16'd0) begin
      o = end_line(o, lw);
    end else begin
      o.phase = (s.active == CH_DELTA) ? PH_SKIP : PH_SIZE;
    end
    return o;
  endfunction

  logic [7:0]  b;
  logic [15:0] word;
  logic [31:0] prod;
  logic        neg;
  logic [8:0]  mag;
  logic        literal;
  logic [1:0]  comp_inc;

  assign b        = item.data_byte;
  assign word     = {b, st_r.hold};
  assign prod     = word * line_width;
  assign neg      = b[7];
  assign mag      = neg ? (9'd256 - {1'b0, b}) : {1'b0, b};
  assign literal  = (st_r.active == CH_DELTA) ? (!neg && b != 8'd0) : neg;
  assign comp_inc = st_r.comp_idx + 2'd1;

  // Next state and result
  always_comb begin
    st_nxt            = st_r;
    res.emit          = 1'b0;
    res.item.kind     = KIND_LIT;
    res.item.address  = st_r.cursor;
    res.item.run_count = 16'd1;
    res.item.value    = b;
    if (advance) begin
      if (item.operation == OP_START) begin
        st_nxt.active = CH_NONE;
        st_nxt.phase  = PH_W0_LO;
        unique case (item.chunk_type)
          CT_COLOR: begin
            st_nxt.active   = CH_COLOR;
            st_nxt.pal_idx  = 8'd0;
            st_nxt.comp_idx = 2'd0;
          end
          CT_DELTA: begin
            st_nxt.active = CH_DELTA;
          end
          CT_BLACK: begin
            res.emit           = 1'b1;
            res.item.kind      = KIND_FILL;
            res.item.address   = 16'd0;
            res.item.run_count = FRAME_CNT;
            res.item.value     = 8'd0;
          end
          CT_BRUN: begin
            st_nxt.active     = (RUN_CNT == 16'd0) ? CH_NONE : CH_BRUN;
            st_nxt.line_addr  = 16'd0;
            st_nxt.cursor     = 16'd0;
            st_nxt.lines_left = RUN_CNT;
            st_nxt.phase      = PH_PKTS;
          end
          CT_COPY: begin
            st_nxt.active    = (FRAME_CNT == 16'd0) ? CH_NONE : CH_COPY;
            st_nxt.cursor    = 16'd0;
            st_nxt.copy_left = FRAME_CNT;
          end
          default: begin
          end
        endcase
      end else if (st_r.active == CH_NONE) begin
        // drop bytes outside a chunk
      end else if (st_r.active == CH_COPY) begin
        res.emit         = 1'b1;
        st_nxt.cursor    = st_r.cursor + 16'd1;
        st_nxt.copy_left = st_r.copy_left - 16'd1;
        if (st_nxt.copy_left == 16'd0) begin
          st_nxt.active = CH_NONE;
        end
      end else begin
        unique case (st_r.phase)
          PH_W0_LO: begin
            st_nxt.hold  = b;
            st_nxt.phase = PH_W0_HI;
          end
          PH_W1_LO: begin
            st_nxt.hold  = b;
            st_nxt.phase = PH_W1_HI;
          end
          PH_W0_HI: begin
            if (st_r.active == CH_COLOR) begin
              st_nxt.pkts_left = word;
              if (word == 16'd0) begin
                st_nxt.active = CH_NONE;
              end else begin
                st_nxt.phase = PH_PSKIP;
              end
            end else begin
              st_nxt.line_addr = prod[15:0];
              st_nxt.phase     = PH_W1_LO;
            end
          end
          PH_W1_HI: begin
            st_nxt.lines_left = word;
            if (word == 16'd0) begin
              st_nxt.active = CH_NONE;
            end else begin
              st_nxt.cursor = st_r.line_addr;
              st_nxt.phase  = PH_PKTS;
            end
          end
          PH_PKTS: begin
            if (b == 8'd0) begin
              st_nxt = end_line(st_r, line_width);
            end else begin
              st_nxt.pkts_left = {8'd0, b};
              st_nxt.phase = (st_r.active == CH_DELTA) ? PH_SKIP : PH_SIZE;
            end
          end
          PH_SKIP: begin
            st_nxt.cursor = st_r.cursor + {8'd0, b};
            st_nxt.phase  = PH_SIZE;
          end
          PH_SIZE: begin
            st_nxt.run_left = mag;
            st_nxt.phase    = literal ? PH_LIT : PH_FILL;
          end
          PH_LIT: begin
            res.emit        = 1'b1;
            st_nxt.cursor   = st_r.cursor + 16'd1;
            st_nxt.run_left = st_r.run_left - 9'd1;
            if (st_nxt.run_left == 9'd0) begin
              st_nxt = end_packet(st_nxt, line_width);
            end
          end
          PH_FILL: begin
            if (st_r.run_left != 9'd0) begin
              res.emit           = 1'b1;
              res.item.kind      = KIND_FILL;
              res.item.run_count = {7'd0, st_r.run_left};
              st_nxt.cursor      = st_r.cursor + {7'd0, st_r.run_left};
            end
            st_nxt = end_packet(st_nxt, line_width);
          end
          PH_PSKIP: begin
            st_nxt.pal_idx = st_r.pal_idx + b;
            st_nxt.phase   = PH_PNUM;
          end
          PH_PNUM: begin
            st_nxt.run_left = (b == 8'd0) ? 9'd256 : {1'b0, b};
            st_nxt.comp_idx = 2'd0;
            st_nxt.phase    = PH_COMP;
          end
          PH_COMP: begin
            res.emit         = 1'b1;
            res.item.kind    = KIND_PAL;
            res.item.address = {8'd0, st_r.pal_idx} + {7'd0, st_r.pal_idx, 1'b0}
                               + {14'd0, st_r.comp_idx};
            st_nxt.comp_idx  = comp_inc;
            if (st_r.comp_idx == 2'd2) begin
              st_nxt.comp_idx = 2'd0;
              st_nxt.pal_idx  = st_r.pal_idx + 8'd1;
              st_nxt.run_left = st_r.run_left - 9'd1;
              if (st_nxt.run_left == 9'd0) begin
                st_nxt.pkts_left = st_r.pkts_left - 16'd1;
                if (st_nxt.pkts_left == 16'd0) begin
                  st_nxt.active = CH_NONE;
                end else begin
                  st_nxt.phase = PH_PSKIP;
                end
              end
            end
          end
          default: begin
            st_nxt.active = CH_NONE;
          end
        endcase
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{active: CH_NONE, phase: PH_W0_LO, default: '0};
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/fcd_out_reg.sv */
// ----------------------------------------------------------------------------
// fcd_out_reg: result register
// Holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_out_reg import fcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_req_t  res,
  input  logic      out_stall,
  output logic      free,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // Slot can take a new result when empty or being drained
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res.emit) begin
      item_r <= res.item;
    end
  end

endmodule

/* rtl/flic_chunk_decoder.sv */
// ----------------------------------------------------------------------------
// flic_chunk_decoder: FLI animation chunk payload decoder
// Turns chunk starts and payload bytes into frame buffer and palette writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : input requests (chunk start with type, or one payload byte).
//   out_*  : result requests: literal pixel, fill run, or palette component.
//   cfg_*  : writes line_width (bytes per frame buffer line); always ready,
//            write only while the decoder is idle.
// Throughput: one input request per cycle, sustained while out_stall is low.
//   Each request is decoded combinationally between the input register
//   and the result register; the line-delta start address uses one 16x16
//   multiplier in the decode logic.
// Results: a request is held in the input register, decoded, and its
//   result is registered in the result register when that is free. A
//   request yields zero or one result.
// Stall: while out_stall holds a pending result, the input register fills
//   and in_stall rises on the following request; nothing is lost.
// Reset: synchronous, active low; clears all decoder state, no chunk active,
//   line_width returns to 320. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flic_chunk_decoder import fcd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int unsigned RUN_LINES   = RUN_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_free;
  logic        advance;
  res_req_t    res;
  logic [15:0] line_width_r;
  logic [15:0] line_width_nxt;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_comb begin
    line_width_nxt = line_width_r;
    if (cfg_valid && cfg_ready) begin
      line_width_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
    end else begin
      line_width_r <= line_width_nxt;
    end
  end

  // Advance a held request when the result slot is free
  assign advance = in_valid_r && out_free;

  fcd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (advance),
    .valid_r  (in_valid_r),
    .item_r   (in_item_r)
  );

  fcd_engine #(
    .FRAME_BYTES (FRAME_BYTES),
    .RUN_LINES   (RUN_LINES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .item       (in_item_r),
    .line_width (line_width_r),
    .res        (res)
  );

  fcd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Stall is raised only with a request held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("in_stall without a held request");

  // A held request that cannot advance must stay for the next cycle
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(in_item_r))
    else $error("held request lost while output blocked");

  // Non-fill results carry a count of one; fills never carry zero
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.kind == KIND_FILL) ? (out_item.run_count != 16'd0)
                                                 : (out_item.run_count == 16'd1)))
    else $error("bad run_count for result kind");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_valid_r)
    else $error("pipeline not empty after reset");

endmodule
